// ===== hdl/sld_pkg.sv =====
// Shared types, constants and CRC function of the sync/length deframer.
`default_nettype none
package sld_pkg;

    localparam int SYNC_BYTES_DEF = 3;
    localparam int SYNC_MAX       = 8;
    localparam int PAT_W          = 24;
    localparam int LEN_W          = 16;
    localparam int CFG_IDX_W      = 2;

    localparam logic [PAT_W-1:0]     SYNC_PATTERN_RST = 24'h564F52;
    localparam logic [LEN_W-1:0]     MAX_LEN_RST      = 16'd1024;
    localparam logic [LEN_W-1:0]     MIN_LEN          = 16'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_PATTERN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN      = 2'd1;

    localparam logic       KIND_DATA   = 1'b0;
    localparam logic       KIND_STATUS = 1'b1;

    localparam logic [1:0] ST_GOOD    = 2'd0;
    localparam logic [1:0] ST_CRC_ERR = 2'd1;
    localparam logic [1:0] ST_BAD_LEN = 2'd2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef struct packed {
        logic [PAT_W-1:0] sync_pattern;
        logic [LEN_W-1:0] max_len;
    } t_cfg;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [15:0] frame_type;
        logic [1:0]  status;
        logic        last;
    } t_result;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/sync_length_crc16_deframer.sv =====
// A byte waits in the input register; any result enters the result register
// when that register is free or being taken. Throughput: one byte per cycle
// while no result waits on a full result register, set by the single
// byte-wide CRC update and parser step between the input and result registers.
// Reset: synchronous, active low; parser returns to hunting with a cleared
// history and the configuration registers take their defaults.
`default_nettype none
module sync_length_crc16_deframer
    import sld_pkg::*;
#(
    parameter int SYNC_BYTES = SYNC_BYTES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [7:0]           i_rx_byte,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic                      o_kind,
    output logic [7:0]                o_data_byte,
    output logic [15:0]               o_frame_type,
    output logic [1:0]                o_status,
    output logic                      o_last,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [PAT_W-1:0]     i_cfg_data
);

    t_cfg       cfg;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    logic       res_valid;
    t_result    res;
    logic       out_free;
    logic       advance;

    sld_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    sld_core #(
        .SYNC_BYTES (SYNC_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_byte      (r_in_byte),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && (!res_valid || out_free);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance && res_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_out.kind;
    assign o_data_byte  = r_out.data_byte;
    assign o_frame_type = r_out.frame_type;
    assign o_status     = r_out.status;
    assign o_last       = r_out.last;

endmodule
`default_nettype wire

// ===== hdl/sld_cfg.sv =====
// Configuration registers of the deframer.
`default_nettype none
module sld_cfg
    import sld_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [PAT_W-1:0]     i_cfg_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_pattern <= SYNC_PATTERN_RST;
            r_cfg.max_len      <= MAX_LEN_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SYNC_PATTERN: r_cfg.sync_pattern <= i_cfg_data;
                CFG_MAX_LEN:      r_cfg.max_len      <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

endmodule
`default_nettype wire

// ===== hdl/sld_core.sv =====
// Frame parser state, running CRC and result decode for one byte a cycle when stepped.
`default_nettype none
module sld_core
    import sld_pkg::*;
#(
    parameter int SYNC_BYTES = SYNC_BYTES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_byte,
    input  wire t_cfg       i_cfg,
    output logic            o_res_valid,
    output t_result         o_res
);

    localparam int WIN_W = 8 * SYNC_BYTES;

    typedef enum logic [2:0] {
        PH_HUNT, PH_LEN_LO, PH_LEN_HI, PH_TYPE_LO,
        PH_TYPE_HI, PH_DATA, PH_CRC_LO, PH_CRC_HI
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [WIN_W-1:0]  r_recent, n_recent;
    logic [7:0]        r_len_lo, n_len_lo;
    logic [LEN_W-1:0]  r_left, n_left;
    logic [15:0]       r_type, n_type;
    logic [15:0]       r_crc, n_crc;
    logic [7:0]        r_crc_lo, n_crc_lo;

    logic [8*SYNC_MAX-1:0] pat_ext;
    logic [WIN_W-1:0]      window;
    logic [WIN_W-1:0]      expect_win;
    logic [15:0]           sync_crc;
    logic [15:0]           crc_upd;
    logic [LEN_W-1:0]      len;

    assign pat_ext = {{(8*SYNC_MAX-PAT_W){1'b0}}, i_cfg.sync_pattern};
    assign window  = (r_recent << 8) | WIN_W'(i_byte);
    assign crc_upd = crc16_byte(r_crc, i_byte);
    assign len     = {i_byte, r_len_lo};

    always_comb begin
        expect_win = '0;
        sync_crc   = CRC_INIT;
        for (int k = 0; k < SYNC_BYTES; k++) begin
            expect_win[8*(SYNC_BYTES-1-k) +: 8] = pat_ext[8*k +: 8];
            sync_crc = crc16_byte(sync_crc, pat_ext[8*k +: 8]);
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_recent    = r_recent;
        n_len_lo    = r_len_lo;
        n_left      = r_left;
        n_type      = r_type;
        n_crc       = r_crc;
        n_crc_lo    = r_crc_lo;
        o_res_valid = 1'b0;
        o_res       = '0;
        case (r_phase)
            PH_HUNT: begin
                if (window == expect_win) begin
                    n_crc    = sync_crc;
                    n_recent = '0;
                    n_phase  = PH_LEN_LO;
                end else begin
                    n_recent = window;
                end
            end
            PH_LEN_LO: begin
                n_len_lo = i_byte;
                n_crc    = crc_upd;
                n_phase  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_crc = crc_upd;
                if (len < MIN_LEN || len > i_cfg.max_len) begin
                    o_res_valid  = 1'b1;
                    o_res.kind   = KIND_STATUS;
                    o_res.status = ST_BAD_LEN;
                    o_res.last   = 1'b1;
                    n_recent     = '0;
                    n_phase      = PH_HUNT;
                end else begin
                    n_left  = len - MIN_LEN;
                    n_phase = PH_TYPE_LO;
                end
            end
            PH_TYPE_LO: begin
                n_type[7:0] = i_byte;
                n_crc       = crc_upd;
                n_phase     = PH_TYPE_HI;
            end
            PH_TYPE_HI: begin
                n_type[15:8] = i_byte;
                n_crc        = crc_upd;
                n_phase      = (r_left != '0) ? PH_DATA : PH_CRC_LO;
            end
            PH_DATA: begin
                n_crc            = crc_upd;
                o_res_valid      = 1'b1;
                o_res.kind       = KIND_DATA;
                o_res.data_byte  = i_byte;
                o_res.frame_type = r_type;
                o_res.status     = ST_GOOD;
                n_left           = r_left - 1'b1;
                if (r_left == LEN_W'(1)) begin
                    n_phase = PH_CRC_LO;
                end
            end
            PH_CRC_LO: begin
                n_crc_lo = i_byte;
                n_phase  = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                o_res_valid      = 1'b1;
                o_res.kind       = KIND_STATUS;
                o_res.frame_type = r_type;
                o_res.status     = ({i_byte, r_crc_lo} == r_crc) ? ST_GOOD : ST_CRC_ERR;
                o_res.last       = 1'b1;
                n_recent         = '0;
                n_phase          = PH_HUNT;
            end
            default: begin
                n_recent = '0;
                n_phase  = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_recent <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_recent <= n_recent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_len_lo <= n_len_lo;
            r_left   <= n_left;
            r_type   <= n_type;
            r_crc    <= n_crc;
            r_crc_lo <= n_crc_lo;
        end
    end

    ap_res_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (r_phase == PH_LEN_HI || r_phase == PH_DATA || r_phase == PH_CRC_HI))
        else $error("result outside a result phase");

    ap_data_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_left != '0)
        else $error("data phase with no bytes left");

    ap_end_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res_valid && o_res.last) |=> (r_phase == PH_HUNT && r_recent == '0))
        else $error("frame end did not restart hunting");

    ap_data_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.kind == KIND_DATA) |-> (!o_res.last && o_res.status == ST_GOOD))
        else $error("data item marked as frame end");

endmodule
`default_nettype wire
